FILE: rtl/fldl_pkg.sv
// fldl_pkg: shared widths, action codes and table request types
// for the discovery flood-and-learn forwarder; no dependencies
`default_nettype none

package fldl_pkg;

	localparam int NODE_COUNT = 256;
	localparam int IDX_W      = $clog2(NODE_COUNT);
	localparam int ID_W       = 8;
	localparam int HOP_W      = 8;
	localparam int PORT_W     = 4;
	localparam int ACT_W      = 3;

	typedef enum logic [ACT_W-1:0] {
		ACT_REPLY   = 3'd0,
		ACT_OWN     = 3'd1,
		ACT_LEARNED = 3'd2,
		ACT_DUP     = 3'd3,
		ACT_FORWARD = 3'd4,
		ACT_UNREACH = 3'd5,
		ACT_EXPIRED = 3'd6
	} action_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
	} rd_req_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [PORT_W-1:0] port;
	} wr_req_t;

	typedef struct packed {
		logic              valid;
		logic [PORT_W-1:0] port;
	} rd_rsp_t;

	// true when an identifier has a table entry
	function automatic logic id_in_range(input logic [ID_W-1:0] id);
		return 32'(id) < 32'(NODE_COUNT);
	endfunction

	function automatic logic [IDX_W-1:0] id_to_idx(input logic [ID_W-1:0] id);
		return IDX_W'(id);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/fldl_table.sv
// fldl_table: forwarding table, valid flags in flops plus a port memory
// with registered read; uses fldl_pkg
`default_nettype none

module fldl_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fldl_pkg::rd_req_t rd_req,
	input  wire fldl_pkg::wr_req_t wr_req,
	output fldl_pkg::rd_rsp_t      rd_rsp
);

	logic [fldl_pkg::NODE_COUNT-1:0]  valid_q;
	logic [fldl_pkg::PORT_W-1:0]      port_mem [fldl_pkg::NODE_COUNT];
	logic                             rd_valid_q;
	logic [fldl_pkg::PORT_W-1:0]      rd_port_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_req.en) begin
				valid_q[wr_req.idx] <= 1'b1;
			end
			if (rd_req.en) begin
				rd_valid_q <= valid_q[rd_req.idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			port_mem[wr_req.idx] <= wr_req.port;
		end
		if (rd_req.en) begin
			rd_port_q <= port_mem[rd_req.idx];
		end
	end

	assign rd_rsp.valid = rd_valid_q;
	assign rd_rsp.port  = rd_port_q;

endmodule

`default_nettype wire

FILE: rtl/fldl_decide.sv
// fldl_decide: per-item decision from the header and the table read,
// builds the result fields and the learn write; uses fldl_pkg
`default_nettype none

module fldl_decide (
	input  wire logic                          valid,
	input  wire logic                          operation,
	input  wire logic [fldl_pkg::ID_W-1:0]     source_id,
	input  wire logic [fldl_pkg::ID_W-1:0]     dest_id,
	input  wire logic [fldl_pkg::HOP_W-1:0]    hop_limit,
	input  wire logic [fldl_pkg::PORT_W-1:0]   arrival_port,
	input  wire logic                          src_is_me,
	input  wire logic                          dst_is_me,
	input  wire fldl_pkg::rd_rsp_t             rd_rsp,
	output fldl_pkg::wr_req_t                  wr_req,
	output fldl_pkg::action_t                  action,
	output logic [fldl_pkg::PORT_W-1:0]        send_port,
	output logic [fldl_pkg::ID_W-1:0]          send_dest,
	output logic [fldl_pkg::HOP_W-1:0]         send_hop_limit,
	output logic                               flood,
	output logic [fldl_pkg::HOP_W-1:0]         flood_hop_limit
);

	logic hop_nz;

	assign hop_nz = hop_limit != '0;

	always_comb begin
		action          = fldl_pkg::ACT_REPLY;
		send_port       = '0;
		send_dest       = '0;
		send_hop_limit  = '0;
		flood           = 1'b0;
		flood_hop_limit = '0;
		wr_req.en       = 1'b0;
		wr_req.idx      = fldl_pkg::id_to_idx(source_id);
		wr_req.port     = arrival_port;
		if (!operation) begin
			if (src_is_me) begin
				action = fldl_pkg::ACT_OWN;
			end else begin
				action         = fldl_pkg::ACT_REPLY;
				send_port      = arrival_port;
				send_dest      = source_id;
				send_hop_limit = hop_limit;
				if (hop_nz) begin
					flood           = 1'b1;
					flood_hop_limit = hop_limit - 1'b1;
				end
			end
		end else if (dst_is_me) begin
			// learn the source's port on first reply only
			if (fldl_pkg::id_in_range(source_id) && !rd_rsp.valid) begin
				action    = fldl_pkg::ACT_LEARNED;
				wr_req.en = valid;
			end else begin
				action = fldl_pkg::ACT_DUP;
			end
		end else if (hop_nz) begin
			if (fldl_pkg::id_in_range(dest_id) && rd_rsp.valid) begin
				action         = fldl_pkg::ACT_FORWARD;
				send_port      = rd_rsp.port;
				send_dest      = dest_id;
				send_hop_limit = hop_limit;
			end else begin
				action = fldl_pkg::ACT_UNREACH;
			end
		end else begin
			action = fldl_pkg::ACT_EXPIRED;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/discovery_flood_and_learn_forwarder_unit.sv
// discovery_flood_and_learn_forwarder_unit: top level, header capture,
// table lookup and result register; uses fldl_pkg, fldl_table, fldl_decide
//
// channel   ports                                          handshake
// --------  ---------------------------------------------  -------------------------
// config    cfg_we, cfg_wdata (my_id)                      written when cfg_we high
// input     operation, source_id, dest_id, hop_limit,      taken when start && !busy
//           arrival_port
// result    action, send_port, send_dest, send_hop_limit,  valid while done high,
//           flood, flood_hop_limit                         one cycle, no stall
//
// for each item the accept edge issues the table read, and the next
// edge writes any learned entry and loads the result registers
// busy is high for the one cycle the table read is in flight, so no new item
// is accepted while it is high; the learn write is not forwarded to a read
// done and the result appear at the edge where busy falls and last one cycle
// reset clears my_id, all table valid flags and the control flags
`default_nettype none

module discovery_flood_and_learn_forwarder_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [fldl_pkg::ID_W-1:0]     cfg_wdata,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          operation,
	input  wire logic [fldl_pkg::ID_W-1:0]     source_id,
	input  wire logic [fldl_pkg::ID_W-1:0]     dest_id,
	input  wire logic [fldl_pkg::HOP_W-1:0]    hop_limit,
	input  wire logic [fldl_pkg::PORT_W-1:0]   arrival_port,
	output logic                               done,
	output logic [fldl_pkg::ACT_W-1:0]         action,
	output logic [fldl_pkg::PORT_W-1:0]        send_port,
	output logic [fldl_pkg::ID_W-1:0]          send_dest,
	output logic [fldl_pkg::HOP_W-1:0]         send_hop_limit,
	output logic                               flood,
	output logic [fldl_pkg::HOP_W-1:0]         flood_hop_limit
);

	logic [fldl_pkg::ID_W-1:0]    my_id_q;
	logic                         accept;
	logic                         dst_is_me;
	logic                         valid_s1;
	logic                         op_s1;
	logic [fldl_pkg::ID_W-1:0]    src_s1;
	logic [fldl_pkg::ID_W-1:0]    dst_s1;
	logic [fldl_pkg::HOP_W-1:0]   hop_s1;
	logic [fldl_pkg::PORT_W-1:0]  port_s1;
	logic                         src_me_s1;
	logic                         dst_me_s1;

	fldl_pkg::rd_req_t            rd_req;
	fldl_pkg::rd_rsp_t            rd_rsp;
	fldl_pkg::wr_req_t            wr_req;

	fldl_pkg::action_t            act_d;
	logic [fldl_pkg::PORT_W-1:0]  send_port_d;
	logic [fldl_pkg::ID_W-1:0]    send_dest_d;
	logic [fldl_pkg::HOP_W-1:0]   send_hop_d;
	logic                         flood_d;
	logic [fldl_pkg::HOP_W-1:0]   flood_hop_d;

	logic                         done_q;
	logic [fldl_pkg::ACT_W-1:0]   action_q;
	logic [fldl_pkg::PORT_W-1:0]  send_port_q;
	logic [fldl_pkg::ID_W-1:0]    send_dest_q;
	logic [fldl_pkg::HOP_W-1:0]   send_hop_q;
	logic                         flood_q;
	logic [fldl_pkg::HOP_W-1:0]   flood_hop_q;

	assign busy      = valid_s1;
	assign accept    = start && !busy;
	assign dst_is_me = dest_id == my_id_q;

	// a reply to this node looks up its source, any other reply its destination
	assign rd_req.en  = accept;
	assign rd_req.idx = fldl_pkg::id_to_idx(dst_is_me ? source_id : dest_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_id_q  <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				my_id_q <= cfg_wdata;
			end
			valid_s1 <= accept;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= operation;
			src_s1    <= source_id;
			dst_s1    <= dest_id;
			hop_s1    <= hop_limit;
			port_s1   <= arrival_port;
			src_me_s1 <= source_id == my_id_q;
			dst_me_s1 <= dst_is_me;
		end
		if (valid_s1) begin
			action_q    <= act_d;
			send_port_q <= send_port_d;
			send_dest_q <= send_dest_d;
			send_hop_q  <= send_hop_d;
			flood_q     <= flood_d;
			flood_hop_q <= flood_hop_d;
		end
	end

	fldl_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_req (rd_req),
		.wr_req (wr_req),
		.rd_rsp (rd_rsp)
	);

	fldl_decide u_decide (
		.valid           (valid_s1),
		.operation       (op_s1),
		.source_id       (src_s1),
		.dest_id         (dst_s1),
		.hop_limit       (hop_s1),
		.arrival_port    (port_s1),
		.src_is_me       (src_me_s1),
		.dst_is_me       (dst_me_s1),
		.rd_rsp          (rd_rsp),
		.wr_req          (wr_req),
		.action          (act_d),
		.send_port       (send_port_d),
		.send_dest       (send_dest_d),
		.send_hop_limit  (send_hop_d),
		.flood           (flood_d),
		.flood_hop_limit (flood_hop_d)
	);

	assign done            = done_q;
	assign action          = action_q;
	assign send_port       = send_port_q;
	assign send_dest       = send_dest_q;
	assign send_hop_limit  = send_hop_q;
	assign flood           = flood_q;
	assign flood_hop_limit = flood_hop_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// tb_top: self-checking bench for discovery_flood_and_learn_forwarder_unit
// drives packet headers under random sender gaps, predicts each verdict and checks it
// depends on fldl_pkg and the rtl of the forwarder
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic                        operation;
		logic [fldl_pkg::ID_W-1:0]   source_id;
		logic [fldl_pkg::ID_W-1:0]   dest_id;
		logic [fldl_pkg::HOP_W-1:0]  hop_limit;
		logic [fldl_pkg::PORT_W-1:0] arrival_port;
	} header_t;

	typedef struct {
		fldl_pkg::action_t           action;
		logic [fldl_pkg::PORT_W-1:0] send_port;
		logic [fldl_pkg::ID_W-1:0]   send_dest;
		logic [fldl_pkg::HOP_W-1:0]  send_hop_limit;
		logic                        flood;
		logic [fldl_pkg::HOP_W-1:0]  flood_hop_limit;
	} verdict_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [fldl_pkg::ID_W-1:0]     cfg_wdata = '0;
	logic                          start = 1'b0;
	logic                          operation = 1'b0;
	logic [fldl_pkg::ID_W-1:0]     source_id = '0;
	logic [fldl_pkg::ID_W-1:0]     dest_id = '0;
	logic [fldl_pkg::HOP_W-1:0]    hop_limit = '0;
	logic [fldl_pkg::PORT_W-1:0]   arrival_port = '0;
	logic                          busy;
	logic                          done;
	logic [fldl_pkg::ACT_W-1:0]    action;
	logic [fldl_pkg::PORT_W-1:0]   send_port;
	logic [fldl_pkg::ID_W-1:0]     send_dest;
	logic [fldl_pkg::HOP_W-1:0]    send_hop_limit;
	logic                          flood;
	logic [fldl_pkg::HOP_W-1:0]    flood_hop_limit;

	header_t  header_q[$];
	verdict_t verdict_q[$];
	header_t  cur_hdr;
	int       idle_pct = 36;
	int       mismatches = 0;
	int       cycle_count = 0;

	// own copy of the node id and the learning table
	logic [fldl_pkg::ID_W-1:0]   node_id = '0;
	logic                        learned_valid [fldl_pkg::NODE_COUNT];
	logic [fldl_pkg::PORT_W-1:0] learned_port [fldl_pkg::NODE_COUNT];
	// ids the generator has taught, used to aim replies at known nodes
	logic [fldl_pkg::ID_W-1:0]   reachable_ids[$];
	logic                        taught [fldl_pkg::NODE_COUNT];

	discovery_flood_and_learn_forwarder_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.source_id      (source_id),
		.dest_id        (dest_id),
		.hop_limit      (hop_limit),
		.arrival_port   (arrival_port),
		.done           (done),
		.action         (action),
		.send_port      (send_port),
		.send_dest      (send_dest),
		.send_hop_limit (send_hop_limit),
		.flood          (flood),
		.flood_hop_limit(flood_hop_limit)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic verdict_t decide_packet(input header_t h);
		verdict_t v;
		v.action          = fldl_pkg::ACT_REPLY;
		v.send_port       = '0;
		v.send_dest       = '0;
		v.send_hop_limit  = '0;
		v.flood           = 1'b0;
		v.flood_hop_limit = '0;
		if (h.operation == 1'b0) begin
			if (h.source_id == node_id) begin
				v.action = fldl_pkg::ACT_OWN;
			end else begin
				v.action         = fldl_pkg::ACT_REPLY;
				v.send_port      = h.arrival_port;
				v.send_dest      = h.source_id;
				v.send_hop_limit = h.hop_limit;
				if (h.hop_limit != 0) begin
					v.flood           = 1'b1;
					v.flood_hop_limit = h.hop_limit - 1'b1;
				end
			end
		end else if (h.dest_id == node_id) begin
			// addressed to us: learn even with a zero hop limit
			if (!learned_valid[h.source_id]) begin
				learned_valid[h.source_id] = 1'b1;
				learned_port[h.source_id]  = h.arrival_port;
				v.action = fldl_pkg::ACT_LEARNED;
			end else begin
				v.action = fldl_pkg::ACT_DUP;
			end
		end else if (h.hop_limit != 0) begin
			if (learned_valid[h.dest_id]) begin
				v.action         = fldl_pkg::ACT_FORWARD;
				v.send_port      = learned_port[h.dest_id];
				v.send_dest      = h.dest_id;
				v.send_hop_limit = h.hop_limit;
			end else begin
				v.action = fldl_pkg::ACT_UNREACH;
			end
		end else begin
			v.action = fldl_pkg::ACT_EXPIRED;
		end
		return v;
	endfunction

	// driver: hold the item until it is taken, then maybe pause before the next
	always @(posedge clk) begin
		if (start && !busy)
			verdict_q.push_back(decide_packet(cur_hdr));
		if (!start || !busy) begin
			if (header_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				cur_hdr = header_q.pop_front();
				start        <= 1'b1;
				operation    <= cur_hdr.operation;
				source_id    <= cur_hdr.source_id;
				dest_id      <= cur_hdr.dest_id;
				hop_limit    <= cur_hdr.hop_limit;
				arrival_port <= cur_hdr.arrival_port;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// monitor: results cannot be held off, so every done cycle is one result
	always @(posedge clk) begin
		verdict_t v;
		if (done) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual action %0d",
					$time, action);
				mismatches++;
			end else begin
				v = verdict_q.pop_front();
				check_field("action", 8'(v.action), 8'(action));
				check_field("send_port", 8'(v.send_port), 8'(send_port));
				check_field("send_dest", v.send_dest, send_dest);
				check_field("send_hop_limit", v.send_hop_limit, send_hop_limit);
				check_field("flood", 8'(v.flood), 8'(flood));
				check_field("flood_hop_limit", v.flood_hop_limit, flood_hop_limit);
			end
		end
	end

	task automatic push_header(input logic op, input logic [7:0] src, input logic [7:0] dst,
			input logic [7:0] hop, input logic [3:0] port);
		header_t h;
		h.operation    = op;
		h.source_id    = src;
		h.dest_id      = dst;
		h.hop_limit    = hop;
		h.arrival_port = port;
		header_q.push_back(h);
	endtask

	// mostly well-formed traffic for the current node id, the rest noise
	function automatic header_t random_header();
		header_t h;
		int r;
		r = $urandom_range(0, 99);
		h.operation    = 1'($urandom);
		h.source_id    = 8'($urandom);
		h.dest_id      = 8'($urandom);
		h.hop_limit    = ($urandom_range(0, 6) == 0) ? 8'd0 : 8'($urandom);
		h.arrival_port = 4'($urandom);
		if (r < 30) begin
			h.operation = 1'b0;
			if ($urandom_range(0, 9) == 0)
				h.source_id = node_id;
		end else if (r < 55) begin
			h.operation = 1'b1;
			h.dest_id   = node_id;
			if (!taught[h.source_id]) begin
				taught[h.source_id] = 1'b1;
				reachable_ids.push_back(h.source_id);
			end
		end else if (r < 90) begin
			h.operation = 1'b1;
			if (reachable_ids.size() != 0 && $urandom_range(0, 3) != 0)
				h.dest_id = reachable_ids[$urandom_range(0, reachable_ids.size() - 1)];
		end
		return h;
	endfunction

	task automatic random_burst(input int count);
		repeat (count) header_q.push_back(random_header());
	endtask

	// sender holds off until the block has answered everything
	task automatic drain();
		while (header_q.size() != 0 || start || verdict_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_node_id(input logic [fldl_pkg::ID_W-1:0] id);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= id;
		@(posedge clk);
		cfg_we  <= 1'b0;
		node_id = id;
	endtask

	initial begin
		for (int i = 0; i < fldl_pkg::NODE_COUNT; i++) begin
			learned_valid[i] = 1'b0;
			learned_port[i]  = '0;
			taught[i]        = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// node id is zero out of reset
		push_header(1'b0, 8'd255, 8'd0, 8'd255, 4'd15);
		push_header(1'b0, 8'd1, 8'd255, 8'd0, 4'd0);
		push_header(1'b0, 8'd2, 8'd0, 8'd1, 4'd7);
		push_header(1'b0, 8'd0, 8'd44, 8'd9, 4'd3);
		push_header(1'b1, 8'd5, 8'd0, 8'd20, 4'd3);
		push_header(1'b1, 8'd5, 8'd0, 8'd20, 4'd8);
		// zero hop limit to us still learns, then counts as duplicate
		push_header(1'b1, 8'd7, 8'd0, 8'd0, 4'd15);
		push_header(1'b1, 8'd7, 8'd0, 8'd0, 4'd1);
		push_header(1'b1, 8'd255, 8'd0, 8'd255, 4'd0);
		push_header(1'b1, 8'd99, 8'd5, 8'd9, 4'd12);
		push_header(1'b1, 8'd99, 8'd7, 8'd255, 4'd0);
		push_header(1'b1, 8'd0, 8'd255, 8'd1, 4'd6);
		push_header(1'b1, 8'd99, 8'd9, 8'd1, 4'd6);
		push_header(1'b1, 8'd99, 8'd5, 8'd0, 4'd6);
		push_header(1'b1, 8'd255, 8'd200, 8'd0, 4'd15);
		drain();

		write_node_id(8'd255);
		push_header(1'b0, 8'd255, 8'd0, 8'd3, 4'd4);
		push_header(1'b1, 8'd0, 8'd255, 8'd3, 4'd9);
		push_header(1'b1, 8'd5, 8'd255, 8'd3, 4'd2);
		push_header(1'b1, 8'd44, 8'd0, 8'd128, 4'd11);
		push_header(1'b1, 8'd44, 8'd255, 8'd0, 4'd11);
		random_burst(400);
		drain();

		write_node_id(8'($urandom_range(1, 254)));
		idle_pct = 78;
		random_burst(400);
		drain();

		write_node_id(8'd0);
		idle_pct = 0;
		random_burst(200);
		drain();
		random_burst(250);
		drain();

		repeat (8) @(posedge clk);
		if (mismatches == 0 && verdict_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
